// ----- rtl/lac_pkg.sv -----
// Shared types and constants for the load-cell converter readout with moving-average filter.
package lac_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_PERIOD  = 3'd0,
        REG_ALPHA        = 3'd1,
        REG_SAMPLE_COUNT = 3'd2,
        REG_SAMPLE_GAP   = 3'd3,
        REG_TICKS_PER_MS = 3'd4
    } cfg_reg_t;

    // Register reset values
    localparam logic [15:0] HALF_PERIOD_RST  = 16'd100;
    localparam logic [16:0] ALPHA_RST        = 17'd20972;
    localparam logic [11:0] SAMPLE_COUNT_RST = 12'd100;
    localparam logic [31:0] SAMPLE_GAP_RST   = 32'd5000000;
    localparam logic [19:0] TICKS_PER_MS_RST = 20'd100000;

    // Alpha of one in Q1.16
    localparam logic [16:0] ALPHA_ONE = 17'd65536;

    // Data path widths
    localparam int RAW_W  = 24;
    localparam int FRAC_W = 16;
    localparam int ACC_W  = RAW_W + FRAC_W;

    // Serial frame: data bits, then one extra pulse for gain 128 on channel A
    localparam logic [4:0] DATA_BITS  = 5'd24;
    localparam logic [4:0] FRAME_BITS = 5'd25;

    // Effective configuration, with the zero and saturation cases applied
    typedef struct packed {
        logic [15:0] half_period;
        logic [16:0] alpha;
        logic [11:0] sample_count;
        logic [31:0] sample_gap;
        logic [19:0] ticks_per_ms;
    } cfg_t;

    // Filter control from the sequencer
    typedef struct packed {
        logic seed;
        logic update;
    } ema_ctl_t;

    // Sequencer part of one result item
    typedef struct packed {
        logic                    serial_clock;
        logic                    sample_valid;
        logic signed [RAW_W-1:0] raw_value;
        logic [31:0]             time_ms;
        logic                    last_sample;
        logic                    busy_res;
    } seq_res_t;

endpackage

// ----- rtl/lac_if.sv -----
// Input and result channel interfaces of the converter readout.
interface lac_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic data_pin;

    modport source (output valid, output start_req, output data_pin, input ready);
    modport sink (input valid, input start_req, input data_pin, output ready);
endinterface

interface lac_out_if;
    logic              valid;
    logic              ready;
    logic              serial_clock;
    logic              sample_valid;
    logic signed [23:0] raw_value;
    logic signed [23:0] filtered_value;
    logic [31:0]       time_ms;
    logic              last_sample;
    logic              busy_res;

    modport source (
        output valid, output serial_clock, output sample_valid, output raw_value,
        output filtered_value, output time_ms, output last_sample, output busy_res,
        input ready
    );
    modport sink (
        input valid, input serial_clock, input sample_valid, input raw_value,
        input filtered_value, input time_ms, input last_sample, input busy_res,
        output ready
    );
endinterface

// ----- rtl/lac_cfg.sv -----
// Configuration register file with effective-value clamping.
module lac_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lac_pkg::CFG_DATA_W-1:0]   cfg_data,
    output lac_pkg::cfg_t                    cfg
);

    logic [15:0] half_period_reg;
    logic [16:0] alpha_reg;
    logic [11:0] sample_count_reg;
    logic [31:0] sample_gap_reg;
    logic [19:0] ticks_per_ms_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg  <= lac_pkg::HALF_PERIOD_RST;
            alpha_reg        <= lac_pkg::ALPHA_RST;
            sample_count_reg <= lac_pkg::SAMPLE_COUNT_RST;
            sample_gap_reg   <= lac_pkg::SAMPLE_GAP_RST;
            ticks_per_ms_reg <= lac_pkg::TICKS_PER_MS_RST;
        end
        else if (cfg_we)
        begin
            case (lac_pkg::cfg_reg_t'(cfg_index))
                lac_pkg::REG_HALF_PERIOD:  half_period_reg  <= cfg_data[15:0];
                lac_pkg::REG_ALPHA:        alpha_reg        <= cfg_data[16:0];
                lac_pkg::REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[11:0];
                lac_pkg::REG_SAMPLE_GAP:   sample_gap_reg   <= cfg_data[31:0];
                lac_pkg::REG_TICKS_PER_MS: ticks_per_ms_reg <= cfg_data[19:0];
                default:
                begin
                end
            endcase
        end
    end

    // Zero half period and zero ms rate act as one; alpha saturates at one
    always_comb
    begin
        cfg.half_period  = (half_period_reg == 16'd0) ? 16'd1 : half_period_reg;
        cfg.alpha        = (alpha_reg > lac_pkg::ALPHA_ONE) ? lac_pkg::ALPHA_ONE : alpha_reg;
        cfg.sample_count = sample_count_reg;
        cfg.sample_gap   = sample_gap_reg;
        cfg.ticks_per_ms = (ticks_per_ms_reg == 20'd0) ? 20'd1 : ticks_per_ms_reg;
    end

endmodule

// ----- rtl/lac_ema.sv -----
// Moving-average filter: free-running difference stage, weighted accumulator update.
module lac_ema
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lac_pkg::ema_ctl_t                      ctl,
    input  logic signed [lac_pkg::RAW_W-1:0]       raw_word,
    input  logic [16:0]                            alpha,
    output logic signed [lac_pkg::RAW_W-1:0]       filtered
);

    localparam int ACC_W  = lac_pkg::ACC_W;
    localparam int DIFF_W = ACC_W + 1;
    localparam int PROD_W = DIFF_W + 18;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DIFF_W-1:0] diff_reg;

    logic signed [ACC_W-1:0]  raw_q;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] step_full;
    logic signed [ACC_W-1:0]  acc_upd;
    logic [lac_pkg::RAW_W-1:0] trunc;

    // The converted word settles before the sample tick, so the difference stage below
    // is full by the time the update is taken.
    always_comb
    begin
        raw_q     = {raw_word, {lac_pkg::FRAC_W{1'b0}}};
        diff_next = $signed({raw_q[ACC_W-1], raw_q}) - $signed({acc_reg[ACC_W-1], acc_reg});
    end

    // Weight with the current alpha, floor shift, then add; the sum stays inside the
    // accumulator range
    always_comb
    begin
        prod      = diff_reg * $signed({1'b0, alpha});
        step_full = prod >>> lac_pkg::FRAC_W;
        acc_upd   = acc_reg + step_full[ACC_W-1:0];
        trunc     = acc_upd[ACC_W-1:lac_pkg::FRAC_W];
        // round toward zero for negative values with a fraction
        if (acc_upd[ACC_W-1] && (acc_upd[lac_pkg::FRAC_W-1:0] != '0))
        begin
            trunc = trunc + 24'd1;
        end
        filtered = $signed(trunc);
    end

    // Difference stage (payload)
    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
    end

    // Accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctl.seed)
        begin
            acc_reg <= raw_q;
        end
        else if (ctl.update)
        begin
            acc_reg <= acc_upd;
        end
    end

endmodule

// ----- rtl/lac_seq.sv -----
// Readout sequencer: serial clock phases, bit shifting, run and gap control, ms timestamp.
module lac_seq
#(
    parameter int MAX_COUNT = 2048
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              start_req,
    input  logic                              data_pin,
    input  lac_pkg::cfg_t                     cfg,
    output lac_pkg::ema_ctl_t                 ema_ctl,
    output logic signed [lac_pkg::RAW_W-1:0]  raw_word,
    output lac_pkg::seq_res_t                 res
);

    localparam int RW = $clog2(MAX_COUNT + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_HIGH,
        PH_LOW,
        PH_GAP
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [4:0]                  bit_counter_reg, bit_counter_next;
    logic [31:0]                 phase_timer_reg, phase_timer_next;
    logic [lac_pkg::RAW_W-1:0]   shift_word_reg, shift_word_next;
    logic                        seeded_reg, seeded_next;
    logic [RW-1:0]               remaining_reg, remaining_next;
    logic [19:0]                 ms_prescaler_reg, ms_prescaler_next;
    logic [31:0]                 ms_counter_reg, ms_counter_next;
    logic [31:0]                 time_latch_reg, time_latch_next;

    logic [31:0]   timer_inc;
    logic [31:0]   count_ext;
    logic [31:0]   count_clamp;
    logic [RW-1:0] remaining_dec;
    logic [20:0]   prescaler_inc;
    logic          valid;
    logic          last;
    logic          seed;
    logic          update;

    // Next state for one tick
    always_comb
    begin
        phase_next        = phase_reg;
        bit_counter_next  = bit_counter_reg;
        phase_timer_next  = phase_timer_reg;
        shift_word_next   = shift_word_reg;
        seeded_next       = seeded_reg;
        remaining_next    = remaining_reg;
        time_latch_next   = time_latch_reg;
        valid             = 1'b0;
        last              = 1'b0;
        seed              = 1'b0;
        update            = 1'b0;

        timer_inc     = phase_timer_reg + 32'd1;
        count_ext     = {20'd0, cfg.sample_count};
        count_clamp   = (count_ext > 32'(MAX_COUNT)) ? 32'(MAX_COUNT) : count_ext;
        remaining_dec = (remaining_reg == '0) ? '0 : remaining_reg - RW'(1);

        case (phase_reg)
            PH_IDLE:
            begin
                if (start_req && (cfg.sample_count != 12'd0))
                begin
                    remaining_next  = count_clamp[RW-1:0];
                    seeded_next     = 1'b0;
                    time_latch_next = ms_counter_reg;
                    phase_next      = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                if (!data_pin)
                begin
                    phase_next       = PH_HIGH;
                    phase_timer_next = '0;
                    bit_counter_next = '0;
                    shift_word_next  = '0;
                end
            end
            PH_HIGH:
            begin
                if (timer_inc >= {16'd0, cfg.half_period})
                begin
                    // data bit sampled at the end of the high phase
                    if (bit_counter_reg < lac_pkg::DATA_BITS)
                    begin
                        shift_word_next = {shift_word_reg[lac_pkg::RAW_W-2:0], data_pin};
                    end
                    bit_counter_next = bit_counter_reg + 5'd1;
                    phase_next       = PH_LOW;
                    phase_timer_next = '0;
                end
                else
                begin
                    phase_timer_next = timer_inc;
                end
            end
            PH_LOW:
            begin
                if (timer_inc < {16'd0, cfg.half_period})
                begin
                    phase_timer_next = timer_inc;
                end
                else
                begin
                    phase_timer_next = '0;
                    if (bit_counter_reg < lac_pkg::FRAME_BITS)
                    begin
                        phase_next = PH_HIGH;
                    end
                    else if (!seeded_reg)
                    begin
                        // first conversion of a run only loads the filter
                        seed            = 1'b1;
                        seeded_next     = 1'b1;
                        time_latch_next = ms_counter_reg;
                        phase_next      = PH_WAIT;
                    end
                    else
                    begin
                        update         = 1'b1;
                        valid          = 1'b1;
                        remaining_next = remaining_dec;
                        if (remaining_dec == '0)
                        begin
                            last       = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else if (cfg.sample_gap == 32'd0)
                        begin
                            time_latch_next = ms_counter_reg;
                            phase_next      = PH_WAIT;
                        end
                        else
                        begin
                            phase_next = PH_GAP;
                        end
                    end
                end
            end
            PH_GAP:
            begin
                if (timer_inc >= cfg.sample_gap)
                begin
                    phase_timer_next = '0;
                    time_latch_next  = ms_counter_reg;
                    phase_next       = PH_WAIT;
                end
                else
                begin
                    phase_timer_next = timer_inc;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Millisecond timestamp, stepped after the rest of the tick
    always_comb
    begin
        prescaler_inc = {1'b0, ms_prescaler_reg} + 21'd1;
        if (prescaler_inc >= {1'b0, cfg.ticks_per_ms})
        begin
            ms_prescaler_next = '0;
            ms_counter_next   = ms_counter_reg + 32'd1;
        end
        else
        begin
            ms_prescaler_next = prescaler_inc[19:0];
            ms_counter_next   = ms_counter_reg;
        end
    end

    // Result fields and filter control
    always_comb
    begin
        res.serial_clock = (phase_next == PH_HIGH);
        res.sample_valid = valid;
        res.raw_value    = valid ? $signed(shift_word_reg) : '0;
        res.time_ms      = valid ? time_latch_reg : '0;
        res.last_sample  = last;
        res.busy_res     = (phase_next != PH_IDLE) || valid;
        ema_ctl.seed     = accept && seed;
        ema_ctl.update   = accept && update;
        raw_word         = $signed(shift_word_reg);
    end

    // State registers, advanced once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_counter_reg  <= '0;
            phase_timer_reg  <= '0;
            shift_word_reg   <= '0;
            seeded_reg       <= 1'b0;
            remaining_reg    <= '0;
            ms_prescaler_reg <= '0;
            ms_counter_reg   <= '0;
            time_latch_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            bit_counter_reg  <= bit_counter_next;
            phase_timer_reg  <= phase_timer_next;
            shift_word_reg   <= shift_word_next;
            seeded_reg       <= seeded_next;
            remaining_reg    <= remaining_next;
            ms_prescaler_reg <= ms_prescaler_next;
            ms_counter_reg   <= ms_counter_next;
            time_latch_reg   <= time_latch_next;
        end
    end

endmodule

// ----- rtl/loadcell_adc_reader_ema.sv -----
// Top level: two-wire 24-bit converter readout with moving-average filter.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   start_req, data_pin (one clock tick each)
//   out_ch   out  valid/ready   serial_clock, sample_valid, raw_value,
//                               filtered_value, time_ms, last_sample, busy_res
//   cfg      in   cfg_we        cfg_index, cfg_data (write only)
//
// One item in, one item out; an item is taken every cycle unless the result is held.
// The result register frees itself when taken, so input stalls only while it is held.
// The filter difference runs in a free-running stage fed by the settled shift word.
// Reset puts the sequencer idle, clears the filter and the timestamp counters.
module loadcell_adc_reader_ema
#(
    parameter int MAX_COUNT = 2048
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lac_pkg::CFG_DATA_W-1:0]   cfg_data,
    lac_in_if.sink                           in_ch,
    lac_out_if.source                        out_ch
);

    lac_pkg::cfg_t                      cfg;
    lac_pkg::ema_ctl_t                  ema_ctl;
    lac_pkg::seq_res_t                  seq_res;
    logic signed [lac_pkg::RAW_W-1:0]   raw_word;
    logic signed [lac_pkg::RAW_W-1:0]   filtered;
    logic                               accept;

    logic                               out_valid_reg;
    lac_pkg::seq_res_t                  res_reg;
    logic signed [lac_pkg::RAW_W-1:0]   filt_reg;

    lac_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lac_seq
    #(
        .MAX_COUNT (MAX_COUNT)
    )
    u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .start_req (in_ch.start_req),
        .data_pin  (in_ch.data_pin),
        .cfg       (cfg),
        .ema_ctl   (ema_ctl),
        .raw_word  (raw_word),
        .res       (seq_res)
    );

    lac_ema u_ema
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ema_ctl),
        .raw_word (raw_word),
        .alpha    (cfg.alpha),
        .filtered (filtered)
    );

    // Handshake: take an item whenever the result register is free or being drained
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg  <= seq_res;
            filt_reg <= seq_res.sample_valid ? filtered : '0;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.serial_clock   = res_reg.serial_clock;
    assign out_ch.sample_valid   = res_reg.sample_valid;
    assign out_ch.raw_value      = res_reg.raw_value;
    assign out_ch.filtered_value = filt_reg;
    assign out_ch.time_ms        = res_reg.time_ms;
    assign out_ch.last_sample    = res_reg.last_sample;
    assign out_ch.busy_res       = res_reg.busy_res;

endmodule

// ----- tb/tb_loadcell_adc_reader_ema.sv -----
`timescale 1ns / 100ps
// Testbench for the converter readout: predicts every result tick and checks the output stream.
module tb_loadcell_adc_reader_ema;

    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_RUN      = 2048;
    localparam int SHOW_MAX     = 10;

    // First index past the register map; writes there must be ignored
    localparam logic [lac_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;

    // Extreme conversion words: the last two feed the first conversions, any of them later at random
    localparam logic [23:0] EDGE_WORDS [4] = '{24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000000};

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_WAIT,
        SEQ_HIGH,
        SEQ_LOW,
        SEQ_GAP
    } seq_phase_t;

    // One result tick as seen on the output channel
    typedef struct packed {
        logic        sclk;
        logic        svalid;
        logic [23:0] raw;
        logic [23:0] filt;
        logic [31:0] tms;
        logic        last;
        logic        busy;
    } tick_res_t;

    // Directed row: stimulus plus the typed result where it is obvious
    typedef struct packed {
        logic start;
        logic pin;
        logic typed;
        logic sclk;
        logic busy;
    } dir_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [lac_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lac_pkg::CFG_DATA_W-1:0] cfg_data;

    lac_in_if  in_ch ();
    lac_out_if out_ch ();

    loadcell_adc_reader_ema #(
        .MAX_COUNT (MAX_RUN)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Configuration copy held by the predictor
    logic [15:0] cfg_half  = lac_pkg::HALF_PERIOD_RST;
    logic [16:0] cfg_alpha = lac_pkg::ALPHA_RST;
    logic [11:0] cfg_count = lac_pkg::SAMPLE_COUNT_RST;
    logic [31:0] cfg_gap   = lac_pkg::SAMPLE_GAP_RST;
    logic [19:0] cfg_tpm   = lac_pkg::TICKS_PER_MS_RST;

    // Sequencer, filter and timestamp state of the predictor
    seq_phase_t  ph        = SEQ_IDLE;
    logic [4:0]  bits      = '0;
    logic [31:0] tmr       = '0;
    logic [23:0] shreg     = '0;
    longint      acc       = 0;
    logic        seeded    = 1'b0;
    logic [11:0] remaining = '0;
    logic [19:0] presc     = '0;
    logic [31:0] ms        = '0;
    logic [31:0] stamp     = '0;

    tick_res_t awaited_ticks [$];
    tick_res_t seen_tick;
    tick_res_t want_tick;

    logic [23:0] conv_word  = 24'h800000;
    int          words_made = 2;
    int          burst_left = 0;
    int          items_sent = 0;
    int          samples_due = 0;
    int          samples_seen = 0;
    int          runs_ended = 0;
    int          phases_run = 0;
    int          mismatches = 0;
    int          cycles = 0;

    // Receiver stall pattern
    logic [15:0] stall_pat = 16'b1011_0111_1101_1110;
    int          rx_cyc  = 0;
    int          rx_mode = 0;

    dir_row_t dir_rows [24] = '{
        '{0, 1, 1, 0, 0},   // idle, nothing happens
        '{0, 0, 1, 0, 0},   // data line low while idle is ignored
        '{1, 1, 1, 0, 1},   // start: wait for data ready
        '{1, 1, 1, 0, 1},   // start while busy is ignored
        '{0, 0, 1, 1, 1},   // data ready: clock goes high
        '{0, 1, 1, 0, 1},   // sign bit 1
        '{1, 0, 1, 1, 1},
        '{0, 0, 1, 0, 1},
        '{0, 1, 1, 1, 1},
        '{0, 0, 1, 0, 1},
        '{0, 1, 1, 1, 1},
        '{0, 0, 1, 0, 1},
        '{0, 1, 0, 0, 0},
        '{0, 0, 0, 0, 0},
        '{1, 1, 0, 0, 0},
        '{0, 0, 0, 0, 0},
        '{0, 1, 0, 0, 0},
        '{0, 0, 0, 0, 0},
        '{1, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0},
        '{0, 1, 0, 0, 0},
        '{0, 0, 0, 0, 0},
        '{0, 1, 0, 0, 0},
        '{0, 0, 0, 0, 0}
    };

    always #4 clk = ~clk;

    // Half period with zero treated as one
    function automatic logic [31:0] eff_half();
        return (cfg_half == 16'd0) ? 32'd1 : {16'd0, cfg_half};
    endfunction

    // Latch the timestamp and wait for the converter
    function automatic void latch_wait();
        stamp = ms;
        ph    = SEQ_WAIT;
    endfunction

    function automatic void set_cfg(input logic [lac_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [31:0] data);
        case (idx)
            lac_pkg::REG_HALF_PERIOD:  cfg_half  = data[15:0];
            lac_pkg::REG_ALPHA:        cfg_alpha = data[16:0];
            lac_pkg::REG_SAMPLE_COUNT: cfg_count = data[11:0];
            lac_pkg::REG_SAMPLE_GAP:   cfg_gap   = data;
            lac_pkg::REG_TICKS_PER_MS: cfg_tpm   = data[19:0];
            default: ;
        endcase
    endfunction

    // Advance the predictor by one tick and return the result it causes
    function automatic tick_res_t readout_tick(input logic start, input logic pin);
        tick_res_t   r;
        logic [31:0] hp;
        logic [31:0] tpm;
        logic [31:0] t;
        logic [16:0] alpha;
        longint      raw;
        longint      prod;
        r     = '0;
        hp    = eff_half();
        alpha = (cfg_alpha > lac_pkg::ALPHA_ONE) ? lac_pkg::ALPHA_ONE : cfg_alpha;
        tpm   = (cfg_tpm == 20'd0) ? 32'd1 : {12'd0, cfg_tpm};
        case (ph)
            SEQ_IDLE:
            begin
                if (start && cfg_count != 12'd0)
                begin
                    remaining = (cfg_count > MAX_RUN) ? 12'(MAX_RUN) : cfg_count;
                    seeded    = 1'b0;
                    latch_wait();
                end
            end
            SEQ_WAIT:
            begin
                if (!pin)
                begin
                    ph    = SEQ_HIGH;
                    tmr   = '0;
                    bits  = '0;
                    shreg = '0;
                end
            end
            SEQ_HIGH:
            begin
                t = tmr + 32'd1;
                if (t >= hp)
                begin
                    if (bits < lac_pkg::DATA_BITS)
                        shreg = {shreg[22:0], pin};
                    bits = bits + 5'd1;
                    ph   = SEQ_LOW;
                    tmr  = '0;
                end
                else
                    tmr = t;
            end
            SEQ_LOW:
            begin
                t = tmr + 32'd1;
                if (t < hp)
                    tmr = t;
                else
                begin
                    tmr = '0;
                    if (bits < lac_pkg::FRAME_BITS)
                        ph = SEQ_HIGH;
                    else
                    begin
                        raw = longint'($signed(shreg));
                        if (!seeded)
                        begin
                            // first conversion of a run only seeds the filter
                            acc    = raw <<< lac_pkg::FRAC_W;
                            seeded = 1'b1;
                            latch_wait();
                        end
                        else
                        begin
                            // arithmetic shift floors toward minus infinity
                            prod     = ((raw <<< lac_pkg::FRAC_W) - acc) * longint'(alpha);
                            acc      = acc + (prod >>> lac_pkg::FRAC_W);
                            r.svalid = 1'b1;
                            r.raw    = shreg;
                            r.filt   = 24'(acc / 65536);
                            r.tms    = stamp;
                            if (remaining != 12'd0)
                                remaining = remaining - 12'd1;
                            if (remaining == 12'd0)
                            begin
                                r.last = 1'b1;
                                ph     = SEQ_IDLE;
                            end
                            else if (cfg_gap == 32'd0)
                                latch_wait();
                            else
                                ph = SEQ_GAP;
                        end
                    end
                end
            end
            SEQ_GAP:
            begin
                t = tmr + 32'd1;
                if (t >= cfg_gap)
                begin
                    tmr = '0;
                    latch_wait();
                end
                else
                    tmr = t;
            end
            default: ph = SEQ_IDLE;
        endcase

        // timestamp steps after the rest of the tick
        if ({12'd0, presc} + 32'd1 >= tpm)
        begin
            presc = '0;
            ms    = ms + 32'd1;
        end
        else
            presc = presc + 20'd1;

        r.sclk = (ph == SEQ_HIGH);
        r.busy = (ph != SEQ_IDLE) || r.svalid;
        return r;
    endfunction

    // Act as the converter: data ready now and then, word bits on the sampling tick
    function automatic void pick_tick(output logic start, output logic pin);
        start = ($urandom_range(0, 7) == 0);
        pin   = 1'($urandom_range(0, 1));
        case (ph)
            SEQ_IDLE: start = ($urandom_range(0, 3) == 0);
            SEQ_WAIT:
            begin
                pin = ($urandom_range(0, 2) != 0);
                if (!pin)
                begin
                    if (words_made < 4)
                        conv_word = EDGE_WORDS[words_made];
                    else if ($urandom_range(0, 7) == 0)
                        conv_word = EDGE_WORDS[$urandom_range(0, 3)];
                    else
                        conv_word = 24'($urandom);
                    words_made++;
                end
            end
            SEQ_HIGH:
            begin
                // one sampled bit in sixteen is left as noise
                if (tmr + 32'd1 >= eff_half() && bits < lac_pkg::DATA_BITS
                    && $urandom_range(0, 15) != 0)
                    pin = conv_word[5'd23 - bits];
            end
            default: ;
        endcase
    endfunction

    task automatic write_reg(input logic [lac_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        set_cfg(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Send one tick item in bursts with random gaps; record what it must cause
    task automatic send_tick(input logic start, input logic pin, input logic typed,
                             input tick_res_t typed_res);
        tick_res_t r;
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 20);
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.start_req <= start;
        in_ch.data_pin  <= pin;
        do
            @(posedge clk);
        while (!in_ch.ready);
        r = readout_tick(start, pin);
        if (r.svalid)
            samples_due++;
        awaited_ticks.push_back(typed ? typed_res : r);
        items_sent++;
    endtask

    // Stop sending and wait until every result tick is back
    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (awaited_ticks.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic run_phase(input int n);
        logic s;
        logic p;
        for (int i = 0; i < n; i++)
        begin
            pick_tick(s, p);
            send_tick(s, p, 1'b0, '0);
        end
        settle();
        phases_run++;
    endtask

    // Receiver: always ready, fixed pattern, or random stalls, switching between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            rx_cyc++;
            if (rx_cyc % 128 == 0)
                rx_mode = $urandom_range(0, 2);
            case (rx_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= stall_pat[rx_cyc % 16];
                default: out_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Result check against the oldest waiting expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen_tick.sclk   = out_ch.serial_clock;
            seen_tick.svalid = out_ch.sample_valid;
            seen_tick.raw    = out_ch.raw_value;
            seen_tick.filt   = out_ch.filtered_value;
            seen_tick.tms    = out_ch.time_ms;
            seen_tick.last   = out_ch.last_sample;
            seen_tick.busy   = out_ch.busy_res;
            if (awaited_ticks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected result tick at cycle %0d", cycles);
            end
            else
            begin
                want_tick = awaited_ticks.pop_front();
                if (seen_tick.sclk !== want_tick.sclk || seen_tick.svalid !== want_tick.svalid
                    || seen_tick.raw !== want_tick.raw || seen_tick.filt !== want_tick.filt
                    || seen_tick.tms !== want_tick.tms || seen_tick.last !== want_tick.last
                    || seen_tick.busy !== want_tick.busy)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                    begin
                        $display("mismatch at cycle %0d: sclk/valid/raw/filt/ms/last/busy", cycles);
                        $display("  want %b %b %h %h %0d %b %b", want_tick.sclk, want_tick.svalid,
                                 want_tick.raw, want_tick.filt, want_tick.tms, want_tick.last,
                                 want_tick.busy);
                        $display("  got  %b %b %h %h %0d %b %b", seen_tick.sclk, seen_tick.svalid,
                                 seen_tick.raw, seen_tick.filt, seen_tick.tms, seen_tick.last,
                                 seen_tick.busy);
                    end
                end
            end
            if (seen_tick.svalid === 1'b1)
                samples_seen++;
            if (seen_tick.last === 1'b1)
                runs_ended++;
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles,
                     awaited_ticks.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic      s;
        logic      p;
        tick_res_t row_res;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.start_req = 1'b0;
        in_ch.data_pin  = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero half period and ms rate, saturated alpha, two-sample run
        write_reg(lac_pkg::REG_HALF_PERIOD, 32'd0);
        write_reg(lac_pkg::REG_ALPHA, 32'h0001_FFFF);
        write_reg(lac_pkg::REG_SAMPLE_COUNT, 32'd2);
        write_reg(lac_pkg::REG_SAMPLE_GAP, 32'd0);
        write_reg(lac_pkg::REG_TICKS_PER_MS, 32'd0);
        foreach (dir_rows[i])
        begin
            row_res      = '0;
            row_res.sclk = dir_rows[i].sclk;
            row_res.busy = dir_rows[i].busy;
            send_tick(dir_rows[i].start, dir_rows[i].pin, dir_rows[i].typed, row_res);
        end
        settle();
        phases_run++;

        // Reset-value filter weight, short runs with a gap
        write_reg(lac_pkg::REG_HALF_PERIOD, 32'd1);
        write_reg(lac_pkg::REG_ALPHA, 32'(lac_pkg::ALPHA_RST));
        write_reg(lac_pkg::REG_SAMPLE_COUNT, 32'd5);
        write_reg(lac_pkg::REG_SAMPLE_GAP, 32'd3);
        write_reg(lac_pkg::REG_TICKS_PER_MS, 32'd7);
        run_phase(200);

        // Alpha of one follows the input exactly
        write_reg(lac_pkg::REG_HALF_PERIOD, 32'd2);
        write_reg(lac_pkg::REG_ALPHA, 32'(lac_pkg::ALPHA_ONE));
        write_reg(lac_pkg::REG_SAMPLE_COUNT, 32'd3);
        write_reg(lac_pkg::REG_SAMPLE_GAP, 32'd0);
        write_reg(lac_pkg::REG_TICKS_PER_MS, 32'd1);
        run_phase(200);

        // Alpha of zero holds the seed; slowest ms rate
        write_reg(lac_pkg::REG_HALF_PERIOD, 32'd1);
        write_reg(lac_pkg::REG_ALPHA, 32'd0);
        write_reg(lac_pkg::REG_SAMPLE_COUNT, 32'd4);
        write_reg(lac_pkg::REG_SAMPLE_GAP, 32'd1);
        write_reg(lac_pkg::REG_TICKS_PER_MS, 32'h000F_FFFF);
        run_phase(200);

        // Smallest alpha, single-sample runs
        write_reg(lac_pkg::REG_ALPHA, 32'd1);
        write_reg(lac_pkg::REG_SAMPLE_COUNT, 32'd1);
        write_reg(lac_pkg::REG_SAMPLE_GAP, 32'd2);
        write_reg(lac_pkg::REG_TICKS_PER_MS, 32'd3);
        run_phase(200);

        // Zero count ignores starts; bits above a register's width and spare indexes
        write_reg(lac_pkg::REG_SAMPLE_COUNT, 32'd0);
        write_reg(lac_pkg::REG_HALF_PERIOD, 32'h0001_0000);
        write_reg(lac_pkg::REG_ALPHA, 32'hFFFE_0000);
        for (int k = 0; k < 3; k++)
            write_reg(REG_SPARE_LO + 3'(k), $urandom);
        run_phase(100);

        // Longest half period: a conversion that never finishes here
        write_reg(lac_pkg::REG_SAMPLE_COUNT, 32'd2);
        write_reg(lac_pkg::REG_HALF_PERIOD, 32'h0000_FFFF);
        run_phase(150);

        // Random filter weight and timing
        write_reg(lac_pkg::REG_HALF_PERIOD, 32'd3);
        write_reg(lac_pkg::REG_ALPHA, $urandom_range(0, 32'h1FFFF));
        write_reg(lac_pkg::REG_SAMPLE_COUNT, $urandom_range(1, 8));
        write_reg(lac_pkg::REG_SAMPLE_GAP, $urandom_range(1, 5));
        write_reg(lac_pkg::REG_TICKS_PER_MS, $urandom_range(1, 50));
        run_phase(200);

        // Longest gap: the run parks after its first sample
        write_reg(lac_pkg::REG_HALF_PERIOD, 32'd1);
        write_reg(lac_pkg::REG_SAMPLE_COUNT, 32'd6);
        write_reg(lac_pkg::REG_SAMPLE_GAP, 32'hFFFF_FFFF);
        run_phase(150);

        // Bulk: back-to-back conversions until enough samples have come
        write_reg(lac_pkg::REG_SAMPLE_GAP, 32'd0);
        write_reg(lac_pkg::REG_ALPHA, $urandom_range(1, 65535));
        write_reg(lac_pkg::REG_SAMPLE_COUNT, 32'd3);
        write_reg(lac_pkg::REG_TICKS_PER_MS, 32'(lac_pkg::TICKS_PER_MS_RST));
        while ((items_sent < 1600 || samples_due < 40 || ph != SEQ_IDLE) && items_sent < 8000)
        begin
            pick_tick(s, p);
            send_tick(s, p, 1'b0, '0);
        end
        settle();
        phases_run++;

        // Count above the maximum is clamped
        write_reg(lac_pkg::REG_SAMPLE_COUNT, 32'h0000_0FFF);
        write_reg(lac_pkg::REG_SAMPLE_GAP, 32'd4);
        run_phase(250);

        repeat (8) @(posedge clk);
        $display("Sent %0d ticks over %0d config phases; %0d filtered samples, %0d runs ended",
                 items_sent, phases_run, samples_seen, runs_ended);
        $display("Swept half period, filter weight, run length, gap and ms rate to their limits");
        if (mismatches == 0)
            $display("== PASS ==");
        else
        begin
            $display("%0d result ticks failed", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
